// ===== sv/hdlcf_pkg.sv =====
package hdlcf_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  FLAG_ESCAPED = 8'h5E;
    localparam logic [7:0]  ESC_ESCAPED = 8'h5D;
    localparam logic [15:0] FCS_INIT    = 16'hFFFF;
    localparam logic [15:0] FCS_POLY    = 16'h8408;

    // worst case: flag, two escaped bytes per data/fcs-lo/fcs-hi, flag
    localparam int unsigned MAX_BYTES = 8;
    localparam int unsigned IDX_W     = $clog2(MAX_BYTES);
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       first_byte;
        logic       last_byte;
    } t_hf_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_hf_out;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      closes;
    } t_burst;

    // reflected crc-16 update, one bit per step
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/hdlcf_burst.sv =====
module hdlcf_burst (
    input  hdlcf_pkg::t_hf_in  i_item,
    input  logic [15:0]        i_crc,
    output logic [15:0]        o_crc_next,
    output hdlcf_pkg::t_burst  o_burst
);
    import hdlcf_pkg::*;

    logic [15:0]      crc_start;
    logic [15:0]      crc_after;
    logic [15:0]      fcs;
    logic [2:0][7:0]  seg_val;
    logic [2:0]       seg_en;
    logic [CNT_W-1:0] n;

    always_comb begin
        crc_start  = i_item.first_byte ? FCS_INIT : i_crc;
        crc_after  = i_item.has_data ? crc_feed(crc_start, i_item.data_byte) : crc_start;
        fcs        = ~crc_after;
        o_crc_next = i_item.last_byte ? FCS_INIT : crc_after;
    end

    // data byte, fcs low, fcs high: each escaped the same way
    assign seg_val = {fcs[15:8], fcs[7:0], i_item.data_byte};
    assign seg_en  = {i_item.last_byte, i_item.last_byte, i_item.has_data};

    always_comb begin
        n             = '0;
        o_burst.bytes = '0;
        if (i_item.first_byte) begin
            o_burst.bytes[n[IDX_W-1:0]] = FLAG_BYTE;
            n = n + CNT_W'(1);
        end
        for (int i = 0; i < 3; i++) begin
            if (seg_en[i]) begin
                if (seg_val[i] == ESC_BYTE) begin
                    o_burst.bytes[n[IDX_W-1:0]] = ESC_BYTE;
                    n = n + CNT_W'(1);
                    o_burst.bytes[n[IDX_W-1:0]] = ESC_ESCAPED;
                    n = n + CNT_W'(1);
                end else if (seg_val[i] == FLAG_BYTE) begin
                    o_burst.bytes[n[IDX_W-1:0]] = ESC_BYTE;
                    n = n + CNT_W'(1);
                    o_burst.bytes[n[IDX_W-1:0]] = FLAG_ESCAPED;
                    n = n + CNT_W'(1);
                end else begin
                    o_burst.bytes[n[IDX_W-1:0]] = seg_val[i];
                    n = n + CNT_W'(1);
                end
            end
        end
        if (i_item.last_byte) begin
            o_burst.bytes[n[IDX_W-1:0]] = FLAG_BYTE;
            n = n + CNT_W'(1);
        end
        o_burst.count  = n;
        o_burst.closes = i_item.last_byte;
    end

endmodule

// ===== sv/hdlcf_out_stage.sv =====
module hdlcf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hdlcf_pkg::t_burst i_burst,
    output logic              o_load_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output hdlcf_pkg::t_hf_out o_data
);
    import hdlcf_pkg::*;

    logic [MAX_BYTES-1:0][7:0] r_buf;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_close;
    logic                      r_valid;
    logic [CNT_W-1:0]          last_idx;
    logic                      at_last;
    logic                      fire;
    logic                      done;

    assign last_idx  = CNT_W'(r_cnt - CNT_W'(1));
    assign at_last   = (r_idx == last_idx[IDX_W-1:0]);
    assign fire      = r_valid && i_ready;
    assign done      = fire && at_last;
    assign o_load_ok = !r_valid || done;

    assign o_valid          = r_valid;
    assign o_data.out_byte  = r_buf[r_idx];
    assign o_data.run_last  = at_last;
    assign o_data.frame_end = at_last && r_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_cnt   <= i_burst.count;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (fire) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf   <= i_burst.bytes;
            r_close <= i_burst.closes;
        end
    end

endmodule

// ===== sv/hdlc_framer_fcs16_unit.sv =====
// an accepted item is registered in the input stage, then loaded into the output stage
//   once that stage is free; its first line byte is offered from there
// throughput: one line byte per cycle while i_out_ready is high; each item makes
//   0 to 8 line bytes (flag, escaped data, escaped fcs, flag); an empty item
//   skips the output; the next item is taken and built while the current bytes drain
// reset: synchronous, active low; clears the input and output stages, fcs to 0xffff
module hdlc_framer_fcs16_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hdlcf_pkg::t_hf_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hdlcf_pkg::t_hf_out o_out_data
);
    import hdlcf_pkg::*;

    t_hf_in      r_in;
    logic        r_in_valid;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    t_burst      burst;
    logic        load_ok;
    logic        in_move;
    logic        load;

    hdlcf_burst u_burst (
        .i_item     (r_in),
        .i_crc      (r_crc),
        .o_crc_next (n_crc),
        .o_burst    (burst)
    );

    // items that make no byte pass without waiting on the output
    assign in_move    = r_in_valid && (load_ok || burst.count == '0);
    assign load       = in_move && burst.count != '0;
    assign o_in_ready = !r_in_valid || in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_crc      <= FCS_INIT;
        end else begin
            if (in_move) begin
                r_crc <= n_crc;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (in_move) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    hdlcf_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_burst   (burst),
        .o_load_ok (load_ok),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

    a_end_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.out_byte == FLAG_BYTE)
        else $error("frame end on a byte that is not the flag");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.run_last)
        else $error("closing flag not marked as last of its item");

    a_no_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("loaded burst not presented");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && r_in.last_byte |=> r_crc == FCS_INIT)
        else $error("fcs not restarted after a closing item");

endmodule
